// ----- src/bps_pkg.sv -----
package bps_pkg;

	// Request kinds carried in tuser
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	// Pattern kinds of a command
	localparam logic [1:0] KIND_STOP  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_HALF  = 2'd2;
	localparam logic [1:0] KIND_LONG  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_SHORT_ON  = 3'd0;
	localparam logic [2:0] REG_SHORT_GAP = 3'd1;
	localparam logic [2:0] REG_HALF_ON   = 3'd2;
	localparam logic [2:0] REG_HALF_GAP  = 3'd3;
	localparam logic [2:0] REG_LONG_ON   = 3'd4;
	localparam logic [2:0] REG_LONG_GAP  = 3'd5;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned COUNT_W = 8;

	// Register reset values
	localparam logic [TICK_W-1:0] RST_SHORT_ON  = 16'd50;
	localparam logic [TICK_W-1:0] RST_SHORT_GAP = 16'd100;
	localparam logic [TICK_W-1:0] RST_HALF_ON   = 16'd200;
	localparam logic [TICK_W-1:0] RST_HALF_GAP  = 16'd200;
	localparam logic [TICK_W-1:0] RST_LONG_ON   = 16'd1200;
	localparam logic [TICK_W-1:0] RST_LONG_GAP  = 16'd500;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_STOP  = 5'b00010,
		PH_START = 5'b00100,
		PH_ON    = 5'b01000,
		PH_GAP   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] short_on;
		logic [TICK_W-1:0] short_gap;
		logic [TICK_W-1:0] half_on;
		logic [TICK_W-1:0] half_gap;
		logic [TICK_W-1:0] long_on;
		logic [TICK_W-1:0] long_gap;
	} cfg_regs_t;

	typedef struct packed {
		phase_t             phase;
		logic [1:0]         kind;
		logic [COUNT_W-1:0] beeps;
		logic [TICK_W-1:0]  timer;
		logic               drive;
	} seq_state_t;

endpackage

// ----- src/bps_cfg_regs.sv -----
module bps_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata,
	output bps_pkg::cfg_regs_t cfg
);
	import bps_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.short_on  <= RST_SHORT_ON;
			regs_q.short_gap <= RST_SHORT_GAP;
			regs_q.half_on   <= RST_HALF_ON;
			regs_q.half_gap  <= RST_HALF_GAP;
			regs_q.long_on   <= RST_LONG_ON;
			regs_q.long_gap  <= RST_LONG_GAP;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SHORT_ON:  regs_q.short_on  <= cfg_wdata;
				REG_SHORT_GAP: regs_q.short_gap <= cfg_wdata;
				REG_HALF_ON:   regs_q.half_on   <= cfg_wdata;
				REG_HALF_GAP:  regs_q.half_gap  <= cfg_wdata;
				REG_LONG_ON:   regs_q.long_on   <= cfg_wdata;
				REG_LONG_GAP:  regs_q.long_gap  <= cfg_wdata;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ----- src/bps_step.sv -----
module bps_step (
	input  bps_pkg::cfg_regs_t  cfg,
	input  bps_pkg::seq_state_t cur,
	input  logic                req_type,
	input  logic [1:0]          pattern_kind,
	input  logic [7:0]          repeat_count,
	output bps_pkg::seq_state_t nxt
);
	import bps_pkg::*;

	logic [TICK_W-1:0] timer_dec;
	logic [TICK_W-1:0] on_time;
	logic [TICK_W-1:0] gap_time;

	assign timer_dec = (cur.timer != '0) ? cur.timer - 1'b1 : cur.timer;

	always_comb begin
		case (cur.kind)
			KIND_SHORT: begin
				on_time  = cfg.short_on;
				gap_time = cfg.short_gap;
			end
			KIND_HALF: begin
				on_time  = cfg.half_on;
				gap_time = cfg.half_gap;
			end
			default: begin
				on_time  = cfg.long_on;
				gap_time = cfg.long_gap;
			end
		endcase
	end

	always_comb begin
		nxt = cur;
		if (req_type == REQ_CMD) begin
			// timer and buzzer level carry over
			nxt.phase = (pattern_kind == KIND_STOP) ? PH_STOP : PH_START;
			nxt.kind  = pattern_kind;
			nxt.beeps = repeat_count;
		end else begin
			nxt.timer = timer_dec;
			case (cur.phase)
				PH_IDLE: ;
				PH_STOP: begin
					nxt.drive = 1'b0;
					nxt.phase = PH_IDLE;
				end
				PH_START: begin
					if (cur.beeps != '0) begin
						nxt.drive = 1'b1;
						nxt.phase = PH_ON;
						nxt.timer = on_time;
					end else begin
						nxt.phase = PH_STOP;
					end
				end
				PH_ON: begin
					if (timer_dec == '0) begin
						nxt.drive = 1'b0;
						nxt.phase = PH_GAP;
						nxt.timer = gap_time;
					end
				end
				PH_GAP: begin
					if (timer_dec == '0) begin
						if (cur.beeps != '0)
							nxt.beeps = cur.beeps - 1'b1;
						nxt.phase = PH_START;
					end
				end
				default: begin
					nxt.drive = 1'b0;
					nxt.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/beep_pattern_sequencer_core.sv -----
// Channel  | dir | handshake        | payload
// ---------+-----+------------------+---------------------------------------------
// s_       | in  | s_tvalid/tready  | tuser: req_type; tdata: pattern_kind,
//          |     |                  |   repeat_count, zero pad
// m_       | out | m_tvalid/tready  | tdata: buzz_level, busy_res, zero pad
// cfg_     | in  | cfg_we           | cfg_addr index, cfg_wdata value
//
// Two register stages: the input word is captured in the _s1 register, the
// step logic runs on it against the sequencer state and the result lands in
// the output register. One word per cycle sustained while the receiver keeps taking results.
// The s1 stage advances whenever the output register is empty or drained,
// so a held result stalls intake only once s1 also holds a word.
// arst_n clears the sequencer state and the valid flags, and loads the config reset values.
module beep_pattern_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] pattern_kind, [9:2] repeat_count, [15:10] 0
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] buzz_level, [1] busy_res, [7:2] 0
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import bps_pkg::*;

	cfg_regs_t  cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;

	// input stage
	logic       valid_s1;
	logic       req_s1;
	logic [1:0] kind_s1;
	logic [7:0] count_s1;

	// output stage
	logic       out_valid_q;
	logic       buzzer_q;
	logic       busy_q;

	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	bps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bps_step u_step (
		.cfg          (cfg),
		.cur          (state_q),
		.req_type     (req_s1),
		.pattern_kind (kind_s1),
		.repeat_count (count_s1),
		.nxt          (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1   <= s_tuser;
			kind_s1  <= s_tdata[1:0];
			count_s1 <= s_tdata[9:2];
		end
	end

	// sequencer state moves once per word, as the word leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.kind  <= KIND_STOP;
			state_q.beeps <= '0;
			state_q.timer <= '0;
			state_q.drive <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buzzer_q <= state_nxt.drive;
			busy_q   <= (state_nxt.phase != PH_IDLE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, busy_q, buzzer_q};

`ifndef SYNTHESIS
	// the buzzer is only driven while a pattern is active
	a_drive_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.drive |-> (state_q.phase != PH_IDLE))
		else $error("buzzer driven while idle");

	// every word leaving s1 shows up in the output register
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost after s1 advance");

	// a command always leaves the sequencer busy
	a_cmd_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1 == REQ_CMD)) |=> m_tdata[1])
		else $error("command did not report busy");
`endif

endmodule

// ----- test/tb_beep_pattern_sequencer_core.sv -----
module tb_beep_pattern_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bps_pkg::*;

	// Spare register indexes: writes there must be dropped by the block
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam int SETTLE_CYCLES = 4;       // two pipe stages plus margin
	localparam int CYCLE_LIMIT   = 150000;  // far above the slowest legal run
	localparam int MAX_PRINTED   = 30;      // only the first mismatches print

	// One result word: buzzer level and busy flag after the item
	typedef struct packed {
		logic buzzer;
		logic busy;
	} drive_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [1:0] pattern_kind, [9:2] repeat_count, [15:10] 0
	logic        s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] buzz_level, [1] busy_res, [7:2] 0
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	// Shadow of the sequencer, advanced once per accepted input word
	logic [15:0] tick_cfg [0:5];
	phase_t      seq_phase;
	logic [1:0]  seq_kind;
	logic [7:0]  seq_beeps;
	logic [15:0] seq_timer;
	logic        seq_drive;

	drive_word_t pending_drive_q [$];
	drive_word_t head_word;

	int err_count    = 0;
	int words_sent   = 0;
	int words_seen   = 0;
	int reg_writes   = 0;
	int cycle_count  = 0;
	int stall_request = 0;   // hold-off length handed to the receiver
	int stall_left   = 0;
	bit steady_flow  = 0;    // both sides run without gaps while set

	beep_pattern_sequencer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Shadow sequencer
	// ---------------------------------------------------------------
	function automatic logic [15:0] on_ticks(input logic [1:0] k);
		case (k)
			KIND_SHORT: return tick_cfg[REG_SHORT_ON];
			KIND_HALF:  return tick_cfg[REG_HALF_ON];
			default:    return tick_cfg[REG_LONG_ON];
		endcase
	endfunction

	function automatic logic [15:0] gap_ticks(input logic [1:0] k);
		case (k)
			KIND_SHORT: return tick_cfg[REG_SHORT_GAP];
			KIND_HALF:  return tick_cfg[REG_HALF_GAP];
			default:    return tick_cfg[REG_LONG_GAP];
		endcase
	endfunction

	// Commands only swap phase, kind and count; timer and buzzer level carry over.
	// A tick decrements a nonzero timer first, then runs one step.
	function automatic drive_word_t advance_sequencer(input logic req, input logic [1:0] kind,
			input logic [7:0] cnt);
		drive_word_t w;
		if (req == REQ_CMD) begin
			seq_phase = (kind == KIND_STOP) ? PH_STOP : PH_START;
			seq_kind  = kind;
			seq_beeps = cnt;
		end else begin
			if (seq_timer != 0)
				seq_timer = seq_timer - 1'b1;
			case (seq_phase)
				PH_IDLE: ;
				PH_START: begin
					if (seq_beeps != 0) begin
						seq_drive = 1'b1;
						seq_phase = PH_ON;
						seq_timer = on_ticks(seq_kind);
					end else begin
						seq_phase = PH_STOP;
					end
				end
				PH_ON: begin
					if (seq_timer == 0) begin
						seq_phase = PH_GAP;
						seq_drive = 1'b0;
						seq_timer = gap_ticks(seq_kind);
					end
				end
				PH_GAP: begin
					if (seq_timer == 0) begin
						if (seq_beeps != 0)
							seq_beeps = seq_beeps - 1'b1;
						seq_phase = PH_START;
					end
				end
				default: begin
					// stop: silence and fall back to idle
					seq_drive = 1'b0;
					seq_phase = PH_IDLE;
				end
			endcase
		end
		w.buzzer = seq_drive;
		w.busy   = (seq_phase != PH_IDLE);
		return w;
	endfunction

	// Ticks a full pattern needs to run out: start, on and gap per beep
	// (each at least one tick), then a last start and the stop step.
	function automatic int pattern_ticks(input logic [1:0] k, input logic [7:0] cnt);
		int on_t;
		int gap_t;
		on_t  = (on_ticks(k) == 0) ? 1 : int'(on_ticks(k));
		gap_t = (gap_ticks(k) == 0) ? 1 : int'(gap_ticks(k));
		return int'(cnt) * (1 + on_t + gap_t) + 2;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Every accepted output word is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drive_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h", m_tdata));
			end else begin
				head_word = pending_drive_q.pop_front();
				if (m_tdata[0] !== head_word.buzzer)
					report_mismatch($sformatf("word %0d buzz_level %b, want %b",
						words_seen, m_tdata[0], head_word.buzzer));
				if (m_tdata[1] !== head_word.busy)
					report_mismatch($sformatf("word %0d busy_res %b, want %b",
						words_seen, m_tdata[1], head_word.busy));
				if (m_tdata[7:2] !== 6'd0)
					report_mismatch($sformatf("word %0d pad bits %b", words_seen, m_tdata[7:2]));
				words_seen++;
			end
		end
	end

	// Receiver: random back-pressure, a gap-free mode, and a long hold-off
	// counted here once a test asks for one
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request != 0) begin
				stall_left    = stall_request;
				stall_request = 0;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = steady_flow || ($urandom_range(99) >= 34);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Drivers (all called at a falling edge, return at a falling edge)
	// ---------------------------------------------------------------
	task automatic send_word(input logic req, input logic [1:0] kind, input logic [7:0] cnt);
		while (!steady_flow && $urandom_range(99) < 34) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = {6'd0, cnt, kind};
		do
			@(posedge clk);
		while (!s_tready);
		pending_drive_q.push_back(advance_sequencer(req, kind, cnt));
		words_sent++;
		@(negedge clk);
	endtask

	// Tick words carry junk in the command fields half the time
	task automatic send_tick();
		if ($urandom_range(1) == 0)
			send_word(REQ_TICK, KIND_STOP, 8'd0);
		else
			send_word(REQ_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx <= REG_LONG_GAP)
			tick_cfg[idx] = val;
		reg_writes++;
	endtask

	// All six timings, plus a write to a spare index that must not land
	task automatic load_timing(input logic [15:0] so, input logic [15:0] sg,
			input logic [15:0] ho, input logic [15:0] hg,
			input logic [15:0] lo, input logic [15:0] lg);
		write_reg(REG_SHORT_ON, so);
		write_reg(REG_SHORT_GAP, sg);
		write_reg(REG_HALF_ON, ho);
		write_reg(REG_HALF_GAP, hg);
		write_reg(REG_LONG_ON, lo);
		write_reg(REG_LONG_GAP, lg);
		write_reg(($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
			16'($urandom_range(16'hFFFF)));
	endtask

	// Drop valid, wait out all predictions, then let the pipe settle
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_drive_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly patterns with random kind and count, some cut short; the rest are
	// stop commands and raw random words.
	task automatic run_pattern_mix(input int budget);
		int stop_at;
		int pick;
		int n;
		logic [1:0] k;
		logic [7:0] c;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				k = 2'($urandom_range(1, 3));
				c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
				send_word(REQ_CMD, k, c);
				n = pattern_ticks(k, c) + $urandom_range(3);
				if ($urandom_range(4) == 0)
					n = $urandom_range(n);
				if (n > 80)
					n = 80;
				repeat (n) send_tick();
			end else if (pick < 88) begin
				send_word(REQ_CMD, KIND_STOP, 8'($urandom_range(255)));
				repeat ($urandom_range(3)) send_tick();
			end else begin
				repeat ($urandom_range(1, 6))
					send_word(1'($urandom_range(1)), 2'($urandom_range(3)),
						8'($urandom_range(255)));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Register reset values: a full short beep at the default timings,
	// then the start of half and long patterns. No gaps on either side.
	task automatic test_reset_values();
		steady_flow = 1'b1;
		send_word(REQ_CMD, KIND_SHORT, 8'd1);
		repeat (pattern_ticks(KIND_SHORT, 8'd1)) send_tick();
		send_word(REQ_CMD, KIND_HALF, 8'd2);
		repeat (30) send_tick();
		send_word(REQ_CMD, KIND_LONG, 8'd1);
		repeat (20) send_tick();
		send_word(REQ_CMD, KIND_STOP, 8'd0);
		repeat (2) send_tick();
		steady_flow = 1'b0;
		drain_results();
	endtask

	// Corner cases with short timings
	task automatic test_directed();
		load_timing(16'd2, 16'd1, 16'd0, 16'd3, 16'd1, 16'd0);
		send_tick();                                  // tick while idle
		send_word(REQ_CMD, KIND_STOP, 8'd0);          // stop while idle
		send_tick();
		send_word(REQ_CMD, KIND_SHORT, 8'd0);         // zero count: stop, then idle
		repeat (2) send_tick();
		send_word(REQ_CMD, KIND_SHORT, 8'd1);         // one full short beep
		repeat (6) send_tick();
		send_word(REQ_CMD, KIND_HALF, 8'd2);          // zero on-time
		repeat (3) send_tick();
		send_word(REQ_CMD, KIND_LONG, 8'd255);        // replaces a running pattern
		send_tick();                                  // buzzer on
		send_word(REQ_CMD, KIND_SHORT, 8'd3);         // buzzer must stay on
		repeat (2) send_tick();
		send_word(REQ_CMD, KIND_STOP, 8'd0);          // stop with buzzer on
		send_tick();                                  // silenced here
		drain_results();
	endtask

	// All-zero and all-ones timings
	task automatic test_register_extremes();
		load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_pattern_mix(70);
		drain_results();
		load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(REQ_CMD, KIND_LONG, 8'd255);
		repeat (40) send_tick();
		send_word(REQ_CMD, KIND_SHORT, 8'd1);
		repeat (10) send_tick();
		send_word(REQ_CMD, KIND_STOP, 8'd0);
		send_tick();
		drain_results();
	endtask

	// Several random timing sets, mostly short so patterns complete
	task automatic test_random_patterns();
		logic [15:0] t [0:5];
		int pick;
		for (int s = 0; s < 5; s++) begin
			for (int i = 0; i < 6; i++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					t[i] = 16'($urandom_range(4));
				else if (pick < 88)
					t[i] = 16'($urandom_range(1, 12));
				else
					t[i] = 16'($urandom_range(16'hFFFF));
			end
			load_timing(t[0], t[1], t[2], t[3], t[4], t[5]);
			run_pattern_mix(300);
			drain_results();
		end
	endtask

	// Receiver holds off for a long stretch while words keep coming,
	// so the pipe fills and the input stalls
	task automatic test_output_holdoff();
		load_timing(16'd1, 16'd2, 16'd3, 16'd1, 16'd2, 16'd0);
		stall_request = 300;
		run_pattern_mix(60);
		drain_results();
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = REQ_TICK;
		s_tdata   = 16'd0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_SHORT_ON;
		cfg_wdata = 16'd0;

		tick_cfg[REG_SHORT_ON]  = RST_SHORT_ON;
		tick_cfg[REG_SHORT_GAP] = RST_SHORT_GAP;
		tick_cfg[REG_HALF_ON]   = RST_HALF_ON;
		tick_cfg[REG_HALF_GAP]  = RST_HALF_GAP;
		tick_cfg[REG_LONG_ON]   = RST_LONG_ON;
		tick_cfg[REG_LONG_GAP]  = RST_LONG_GAP;
		seq_phase = PH_IDLE;
		seq_kind  = KIND_STOP;
		seq_beeps = 8'd0;
		seq_timer = 16'd0;
		seq_drive = 1'b0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed();
		test_register_extremes();
		test_random_patterns();
		test_output_holdoff();

		if (pending_drive_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_drive_q.size()));

		$display("Ran %0d words, checked %0d result words, %0d register writes, %0d mismatches",
			words_sent, words_seen, reg_writes, err_count);
		$display("Covered reset timings, stop and zero-count cases, extreme and random timings,"
			, " and a long output hold-off");
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
